### design/vkt_pkg.sv
// Shared types, codes and constants for the versioned key table.
// No dependencies; every other design file but vkt_ram refers to this package by scope.
`default_nettype none

package vkt_pkg;

	// Default sizes
	localparam int TABLE_SLOTS_DEF  = 16;
	localparam int MAX_VERSIONS_DEF = 8;

	// Request modes
	localparam logic [2:0] MODE_ADD      = 3'd0;
	localparam logic [2:0] MODE_DEL_KEY  = 3'd1;
	localparam logic [2:0] MODE_DEL_VER  = 3'd2;
	localparam logic [2:0] MODE_FIND_KEY = 3'd3;
	localparam logic [2:0] MODE_FIND_VER = 3'd4;

	// Result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic [4:0]  CAP_RESET = 5'd16;
	localparam logic [30:0] VER_MAX   = 31'h7FFF_FFFF;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [31:0] key;
		logic [30:0]        version;
		logic [15:0]        text_len;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [30:0] found_version;
		logic [31:0] data_offset;
		logic [15:0] data_len;
		logic [3:0]  versions_held;
	} rsp_t;

	// One version record as held in the version store
	typedef struct packed {
		logic [30:0] num;
		logic [31:0] off;
		logic [15:0] len;
	} ver_ent_t;

	// Datapath operations, one per cycle
	typedef enum logic [4:0] {
		OP_NONE     = 5'd0,
		OP_START    = 5'd1,
		OP_SCAN_RD  = 5'd2,
		OP_SCAN_CMP = 5'd3,
		OP_RES_FULL = 5'd4,
		OP_RES_MISS = 5'd5,
		OP_RES_NULL = 5'd6,
		OP_RES_OK0  = 5'd7,
		OP_HEAD_RD  = 5'd8,
		OP_NEW_KEY  = 5'd9,
		OP_HEAD_NUM = 5'd10,
		OP_UP_RD    = 5'd11,
		OP_UP_WR    = 5'd12,
		OP_ADD_WR   = 5'd13,
		OP_VI_CLR   = 5'd14,
		OP_V_RD     = 5'd15,
		OP_V_CMP    = 5'd16,
		OP_RES_HEAD = 5'd17,
		OP_DN_RD    = 5'd18,
		OP_DN_WR    = 5'd19,
		OP_CNT_WR   = 5'd20,
		OP_LAST_RD  = 5'd21,
		OP_MOVE_ENT = 5'd22,
		OP_MV_RD    = 5'd23,
		OP_MV_WR    = 5'd24,
		OP_DROP     = 5'd25,
		OP_EMIT     = 5'd26
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} cmd_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       hit;
		logic       key_eq;
		logic       more;
		logic       n_zero;
		logic       n_full;
		logic       n_le1;
		logic       tbl_full;
		logic       vi_gt0;
		logic       vi_lt_n;
		logic       vi1_lt_n;
		logic       ver_eq;
		logic       last_is_slot;
		logic       out_free;
	} stat_t;

endpackage

`default_nettype wire

### design/vkt_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module vkt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### design/vkt_ctrl.sv
// Controller state machine of the versioned key table.
// Depends on vkt_pkg; drives at most one datapath operation per cycle from its status.
`default_nettype none

module vkt_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire vkt_pkg::stat_t stat,
	output vkt_pkg::cmd_t       cmd
);

	typedef enum logic [18:0] {
		S_IDLE  = 19'b000_0000_0000_0000_0001,
		S_SRD   = 19'b000_0000_0000_0000_0010,
		S_SCMP  = 19'b000_0000_0000_0000_0100,
		S_DISP  = 19'b000_0000_0000_0000_1000,
		S_ADDH  = 19'b000_0000_0000_0001_0000,
		S_UPRD  = 19'b000_0000_0000_0010_0000,
		S_UPWR  = 19'b000_0000_0000_0100_0000,
		S_VRD   = 19'b000_0000_0000_1000_0000,
		S_VCMP  = 19'b000_0000_0001_0000_0000,
		S_DNRD  = 19'b000_0000_0010_0000_0000,
		S_DNWR  = 19'b000_0000_0100_0000_0000,
		S_SK    = 19'b000_0000_1000_0000_0000,
		S_RM    = 19'b000_0001_0000_0000_0000,
		S_RMENT = 19'b000_0010_0000_0000_0000,
		S_MVRD  = 19'b000_0100_0000_0000_0000,
		S_MVWR  = 19'b000_1000_0000_0000_0000,
		S_OUT   = 19'b001_0000_0000_0000_0000,
		S_SPARE = 19'b010_0000_0000_0000_0000,
		S_SPR2  = 19'b100_0000_0000_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	vkt_pkg::dp_op_t op;

	// Take a new item only from idle
	assign req_stall = (state_q != S_IDLE);
	assign cmd.op    = op;

	// Next state and datapath operation
	always_comb begin
		state_d = state_q;
		op      = vkt_pkg::OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					op      = vkt_pkg::OP_START;
					state_d = S_SRD;
				end
			end
			S_SRD: begin
				if (stat.more) begin
					op      = vkt_pkg::OP_SCAN_RD;
					state_d = S_SCMP;
				end else begin
					state_d = S_DISP;
				end
			end
			S_SCMP: begin
				op      = vkt_pkg::OP_SCAN_CMP;
				state_d = stat.key_eq ? S_DISP : S_SRD;
			end
			S_DISP: begin
				state_d = S_OUT;
				case (stat.mode)
					vkt_pkg::MODE_ADD: begin
						if (stat.hit) begin
							if (stat.n_full) begin
								op = vkt_pkg::OP_RES_FULL;
							end else begin
								op      = vkt_pkg::OP_HEAD_RD;
								state_d = S_ADDH;
							end
						end else if (stat.tbl_full) begin
							op = vkt_pkg::OP_RES_FULL;
						end else begin
							op      = vkt_pkg::OP_NEW_KEY;
							state_d = S_UPRD;
						end
					end
					vkt_pkg::MODE_DEL_KEY: begin
						if (stat.hit) begin
							op      = vkt_pkg::OP_RES_OK0;
							state_d = S_RM;
						end else begin
							op = vkt_pkg::OP_RES_NULL;
						end
					end
					vkt_pkg::MODE_DEL_VER, vkt_pkg::MODE_FIND_VER: begin
						if (stat.hit) begin
							op      = vkt_pkg::OP_VI_CLR;
							state_d = S_VRD;
						end else begin
							op = vkt_pkg::OP_RES_NULL;
						end
					end
					vkt_pkg::MODE_FIND_KEY: begin
						if (stat.hit && !stat.n_zero) begin
							op      = vkt_pkg::OP_HEAD_RD;
							state_d = S_SK;
						end else begin
							op = vkt_pkg::OP_RES_NULL;
						end
					end
					default: begin
						op = vkt_pkg::OP_RES_NULL;
					end
				endcase
			end
			S_ADDH: begin
				op      = vkt_pkg::OP_HEAD_NUM;
				state_d = S_UPRD;
			end
			S_UPRD: begin
				if (stat.vi_gt0) begin
					op      = vkt_pkg::OP_UP_RD;
					state_d = S_UPWR;
				end else begin
					op      = vkt_pkg::OP_ADD_WR;
					state_d = S_OUT;
				end
			end
			S_UPWR: begin
				op      = vkt_pkg::OP_UP_WR;
				state_d = S_UPRD;
			end
			S_VRD: begin
				if (stat.vi_lt_n) begin
					op      = vkt_pkg::OP_V_RD;
					state_d = S_VCMP;
				end else begin
					op      = vkt_pkg::OP_RES_MISS;
					state_d = S_OUT;
				end
			end
			S_VCMP: begin
				op = vkt_pkg::OP_V_CMP;
				if (!stat.ver_eq) begin
					state_d = S_VRD;
				end else if (stat.mode != vkt_pkg::MODE_DEL_VER) begin
					state_d = S_OUT;
				end else begin
					state_d = stat.n_le1 ? S_RM : S_DNRD;
				end
			end
			S_DNRD: begin
				if (stat.vi1_lt_n) begin
					op      = vkt_pkg::OP_DN_RD;
					state_d = S_DNWR;
				end else begin
					op      = vkt_pkg::OP_CNT_WR;
					state_d = S_OUT;
				end
			end
			S_DNWR: begin
				op      = vkt_pkg::OP_DN_WR;
				state_d = S_DNRD;
			end
			S_SK: begin
				op      = vkt_pkg::OP_RES_HEAD;
				state_d = S_OUT;
			end
			S_RM: begin
				if (stat.last_is_slot) begin
					op      = vkt_pkg::OP_DROP;
					state_d = S_OUT;
				end else begin
					op      = vkt_pkg::OP_LAST_RD;
					state_d = S_RMENT;
				end
			end
			S_RMENT: begin
				op      = vkt_pkg::OP_MOVE_ENT;
				state_d = S_MVRD;
			end
			S_MVRD: begin
				if (stat.vi_lt_n) begin
					op      = vkt_pkg::OP_MV_RD;
					state_d = S_MVWR;
				end else begin
					op      = vkt_pkg::OP_DROP;
					state_d = S_OUT;
				end
			end
			S_MVWR: begin
				op      = vkt_pkg::OP_MV_WR;
				state_d = S_MVRD;
			end
			S_OUT: begin
				if (stat.out_free) begin
					op      = vkt_pkg::OP_EMIT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

### design/vkt_dp.sv
// Datapath of the versioned key table: slot and version stores, counters,
// result register. Depends on vkt_pkg and vkt_ram; driven by vkt_ctrl.
`default_nettype none

module vkt_dp #(
	parameter int TABLE_SLOTS  = vkt_pkg::TABLE_SLOTS_DEF,
	parameter int MAX_VERSIONS = vkt_pkg::MAX_VERSIONS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire vkt_pkg::req_t req_item,
	input  wire logic          cfg_we,
	input  wire logic [4:0]    cfg_data,
	input  wire logic          rsp_stall,
	output logic               rsp_valid,
	output vkt_pkg::rsp_t      rsp_item,
	input  wire vkt_pkg::cmd_t cmd,
	output vkt_pkg::stat_t     stat
);

	localparam int SIW   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int UW    = $clog2(TABLE_SLOTS + 1);
	localparam int CW    = $clog2(MAX_VERSIONS + 1);
	localparam int VDEP  = TABLE_SLOTS * MAX_VERSIONS;
	localparam int VAW   = (VDEP > 1) ? $clog2(VDEP) : 1;
	localparam int SEW   = 32 + CW;
	localparam int VEW   = $bits(vkt_pkg::ver_ent_t);
	localparam int CMPW  = (UW > 5) ? UW : 5;

	vkt_pkg::req_t   in_q;
	vkt_pkg::rsp_t   res_q;
	logic [UW-1:0]   idx_q;
	logic [UW-1:0]   used_q;
	logic [SIW-1:0]  slot_q;
	logic [CW-1:0]   n_q;
	logic [CW-1:0]   vi_q;
	logic            hit_q;
	logic [30:0]     num_q;
	logic [31:0]     end_q;
	logic [4:0]      cap_q;

	logic            s_we, s_re;
	logic [SIW-1:0]  s_waddr, s_raddr;
	logic [SEW-1:0]  s_wdata, s_rdata;
	logic            v_we, v_re;
	logic [VAW-1:0]  v_waddr, v_raddr;
	logic [VEW-1:0]  v_wdata, v_rdata;

	vkt_pkg::ver_ent_t v_ent;
	logic [31:0]     s_key;
	logic [CW-1:0]   s_cnt;
	logic [SIW-1:0]  last_slot;
	logic [VAW-1:0]  base_a;
	logic [VAW-1:0]  last_a;
	logic [UW-1:0]   used_m1;

	assign v_ent     = vkt_pkg::ver_ent_t'(v_rdata);
	assign s_key     = s_rdata[CW +: 32];
	assign s_cnt     = s_rdata[CW-1:0];
	assign used_m1   = used_q - UW'(1);
	assign last_slot = used_m1[SIW-1:0];
	assign base_a    = VAW'(slot_q) * VAW'(MAX_VERSIONS);
	assign last_a    = VAW'(last_slot) * VAW'(MAX_VERSIONS);

	// Status towards the controller
	always_comb begin
		stat.mode         = in_q.mode;
		stat.hit          = hit_q;
		stat.key_eq       = (s_key == $unsigned(in_q.key));
		stat.more         = (idx_q < used_q);
		stat.n_zero       = (n_q == '0);
		stat.n_full       = (n_q >= CW'(MAX_VERSIONS));
		stat.n_le1        = (n_q <= CW'(1));
		stat.tbl_full     = (CMPW'(used_q) >= CMPW'(cap_q)) ||
		                    (CMPW'(used_q) >= CMPW'(TABLE_SLOTS));
		stat.vi_gt0       = (vi_q != '0);
		stat.vi_lt_n      = (vi_q < n_q);
		stat.vi1_lt_n     = ({1'b0, vi_q} + (CW+1)'(1)) < {1'b0, n_q};
		stat.ver_eq       = (v_ent.num == in_q.version);
		stat.last_is_slot = (slot_q == last_slot);
		stat.out_free     = !rsp_valid || !rsp_stall;
	end

	// Store ports per operation
	always_comb begin
		s_we    = 1'b0;
		s_waddr = slot_q;
		s_wdata = s_rdata;
		s_re    = 1'b0;
		s_raddr = idx_q[SIW-1:0];
		v_we    = 1'b0;
		v_waddr = base_a + VAW'(vi_q);
		v_wdata = v_rdata;
		v_re    = 1'b0;
		v_raddr = base_a + VAW'(vi_q);
		case (cmd.op)
			vkt_pkg::OP_SCAN_RD: s_re = 1'b1;
			vkt_pkg::OP_LAST_RD: begin
				s_re    = 1'b1;
				s_raddr = last_slot;
			end
			vkt_pkg::OP_MOVE_ENT: s_we = 1'b1;
			vkt_pkg::OP_ADD_WR: begin
				s_we    = 1'b1;
				s_wdata = {$unsigned(in_q.key), n_q + CW'(1)};
				v_we    = 1'b1;
				v_waddr = base_a;
				v_wdata = {num_q, end_q, in_q.text_len};
			end
			vkt_pkg::OP_CNT_WR: begin
				s_we    = 1'b1;
				s_wdata = {$unsigned(in_q.key), n_q - CW'(1)};
			end
			vkt_pkg::OP_HEAD_RD: begin
				v_re    = 1'b1;
				v_raddr = base_a;
			end
			vkt_pkg::OP_UP_RD: begin
				v_re    = 1'b1;
				v_raddr = base_a + VAW'(vi_q) - VAW'(1);
			end
			vkt_pkg::OP_V_RD: v_re = 1'b1;
			vkt_pkg::OP_DN_RD: begin
				v_re    = 1'b1;
				v_raddr = base_a + VAW'(vi_q) + VAW'(1);
			end
			vkt_pkg::OP_MV_RD: begin
				v_re    = 1'b1;
				v_raddr = last_a + VAW'(vi_q);
			end
			vkt_pkg::OP_UP_WR, vkt_pkg::OP_DN_WR, vkt_pkg::OP_MV_WR: v_we = 1'b1;
			default: begin
			end
		endcase
	end

	// Working registers and result
	always_ff @(posedge clk) begin
		case (cmd.op)
			vkt_pkg::OP_START: begin
				in_q  <= req_item;
				idx_q <= '0;
				hit_q <= 1'b0;
				n_q   <= '0;
			end
			vkt_pkg::OP_SCAN_RD: idx_q <= idx_q + UW'(1);
			vkt_pkg::OP_SCAN_CMP: begin
				if (stat.key_eq) begin
					hit_q  <= 1'b1;
					slot_q <= SIW'(idx_q - UW'(1));
					n_q    <= s_cnt;
				end
			end
			vkt_pkg::OP_RES_FULL: res_q <= {vkt_pkg::ST_FULL, 31'd0, 32'd0, 16'd0, 4'(n_q)};
			vkt_pkg::OP_RES_MISS: res_q <= {vkt_pkg::ST_MISS, 31'd0, 32'd0, 16'd0, 4'(n_q)};
			vkt_pkg::OP_RES_NULL: res_q <= {vkt_pkg::ST_MISS, 31'd0, 32'd0, 16'd0, 4'd0};
			vkt_pkg::OP_RES_OK0:  res_q <= {vkt_pkg::ST_OK, 31'd0, 32'd0, 16'd0, 4'd0};
			vkt_pkg::OP_NEW_KEY: begin
				slot_q <= used_q[SIW-1:0];
				num_q  <= 31'd1;
				vi_q   <= '0;
			end
			vkt_pkg::OP_HEAD_NUM: begin
				if (n_q == '0) begin
					num_q <= 31'd1;
				end else if (v_ent.num == vkt_pkg::VER_MAX) begin
					num_q <= vkt_pkg::VER_MAX;
				end else begin
					num_q <= v_ent.num + 31'd1;
				end
				vi_q <= n_q;
			end
			vkt_pkg::OP_UP_WR: vi_q <= vi_q - CW'(1);
			vkt_pkg::OP_ADD_WR: begin
				res_q <= {vkt_pkg::ST_OK, num_q, end_q, in_q.text_len, 4'(n_q + CW'(1))};
			end
			vkt_pkg::OP_VI_CLR: vi_q <= '0;
			vkt_pkg::OP_V_CMP: begin
				if (stat.ver_eq) begin
					if (in_q.mode == vkt_pkg::MODE_DEL_VER) begin
						res_q <= {vkt_pkg::ST_OK, v_ent.num, v_ent.off, v_ent.len,
						          4'(n_q - CW'(1))};
					end else begin
						res_q <= {vkt_pkg::ST_OK, v_ent.num, v_ent.off, v_ent.len, 4'(n_q)};
					end
				end else begin
					vi_q <= vi_q + CW'(1);
				end
			end
			vkt_pkg::OP_RES_HEAD: begin
				res_q <= {vkt_pkg::ST_OK, v_ent.num, v_ent.off, v_ent.len, 4'(n_q)};
			end
			vkt_pkg::OP_DN_WR, vkt_pkg::OP_MV_WR: vi_q <= vi_q + CW'(1);
			vkt_pkg::OP_MOVE_ENT: begin
				n_q  <= s_cnt;
				vi_q <= '0;
			end
			vkt_pkg::OP_EMIT: rsp_item <= res_q;
			default: begin
			end
		endcase
	end

	// Table occupancy, data end offset, capacity and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			end_q     <= '0;
			cap_q     <= vkt_pkg::CAP_RESET;
			rsp_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			if (cmd.op == vkt_pkg::OP_NEW_KEY) begin
				used_q <= used_q + UW'(1);
			end else if (cmd.op == vkt_pkg::OP_DROP) begin
				used_q <= used_m1;
			end
			if (cmd.op == vkt_pkg::OP_ADD_WR) begin
				end_q <= end_q + 32'(in_q.text_len);
			end
			if (cmd.op == vkt_pkg::OP_EMIT) begin
				rsp_valid <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	// Slot store: key and version count per slot
	vkt_ram #(.WIDTH(SEW), .DEPTH(TABLE_SLOTS)) u_slot_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.re    (s_re),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	// Version store: MAX_VERSIONS records per slot, newest first
	vkt_ram #(.WIDTH(VEW), .DEPTH(VDEP)) u_ver_ram (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_waddr),
		.wdata (v_wdata),
		.re    (v_re),
		.raddr (v_raddr),
		.rdata (v_rdata)
	);

endmodule

`default_nettype wire

### design/versioned_key_table_top.sv
// Versioned key table: one request at a time; each slot scanned takes a slot store read
// then a compare, and each version compared or moved takes a read and a compare or write
// in the version store. The longest request is a version delete that removes its key and
// moves a full last slot; the next request is taken in the cycle after the result is
// loaded, while it sits in the output register.
// Reset empties the table at once (slot count and data end cleared, capacity 16); no
// clearing pass. Top level; depends on vkt_pkg, vkt_ctrl, vkt_dp and vkt_ram.
`default_nettype none

module versioned_key_table_top #(
	parameter int TABLE_SLOTS  = vkt_pkg::TABLE_SLOTS_DEF,
	parameter int MAX_VERSIONS = vkt_pkg::MAX_VERSIONS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire vkt_pkg::req_t req_item,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output vkt_pkg::rsp_t      rsp_item,
	input  wire logic          cfg_we,
	input  wire logic [4:0]    cfg_data
);

	vkt_pkg::cmd_t  cmd;
	vkt_pkg::stat_t stat;

	// Sequencer
	vkt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Stores and working registers
	vkt_dp #(
		.TABLE_SLOTS  (TABLE_SLOTS),
		.MAX_VERSIONS (MAX_VERSIONS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_item  (req_item),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp_item  (rsp_item),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

`default_nettype wire

### design/vkt_checker.sv
// Port-level checks for the versioned key table, bound to the top level.
// Depends on vkt_pkg and versioned_key_table_top.
`default_nettype none

module vkt_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_stall,
	input wire vkt_pkg::rsp_t rsp_item,
	input wire logic          rsp_valid,
	input wire logic          rsp_stall
);

	// Hold a stalled result item
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
		else $error("result item changed while stalled");

	// No item finishes in the cycle after it is taken
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> !$rose(rsp_valid))
		else $error("result appeared one cycle after accept");

	// Drop all data fields on a failing status
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_item.status != vkt_pkg::ST_OK |->
		rsp_item.found_version == 31'd0 && rsp_item.data_offset == 32'd0 &&
		rsp_item.data_len == 16'd0)
		else $error("failing result carries data");

	// An ok result without a version is a key removal
	a_ok_nover: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_item.status == vkt_pkg::ST_OK && rsp_item.found_version == 31'd0
		|-> rsp_item.versions_held == 4'd0 && rsp_item.data_len == 16'd0)
		else $error("ok result without version holds data");

endmodule

bind versioned_key_table_top vkt_checker u_vkt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_item  (rsp_item),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall)
);

`default_nettype wire

### verif/versioned_key_table_top_test.sv
// Self-checking bench for versioned_key_table_top: drives requests, predicts every response.
// Depends on vkt_pkg and the versioned_key_table_top design sources.
`timescale 1ns / 1ps

module versioned_key_table_top_test;
	import vkt_pkg::*;

	localparam int SLOTS = TABLE_SLOTS_DEF;
	localparam int VERS  = MAX_VERSIONS_DEF;
	localparam int DRAIN = 2 * SLOTS + 4 * VERS + 40;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk, arst_n;
	logic req_valid, req_stall, rsp_valid, rsp_stall, cfg_we;
	req_t req_item;
	rsp_t rsp_item;
	logic [4:0] cfg_data;

	versioned_key_table_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	// Table shadow
	logic [31:0] tbl_key [SLOTS];
	int          tbl_cnt [SLOTS];
	logic [30:0] tbl_num [SLOTS][VERS];
	logic [31:0] tbl_off [SLOTS][VERS];
	logic [15:0] tbl_len [SLOTS][VERS];
	int          keys_held;
	logic [31:0] data_end;
	logic [4:0]  cap_limit;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int   fail_count = 0;
	bit   cfg_busy = 0;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic int find_key(logic [31:0] k);
		for (int i = 0; i < keys_held; i++)
			if (tbl_key[i] == k) return i;
		return -1;
	endfunction

	function automatic void drop_key(int s);
		int last;
		last = keys_held - 1;
		if (s != last) begin
			tbl_key[s] = tbl_key[last];
			tbl_cnt[s] = tbl_cnt[last];
			for (int v = 0; v < VERS; v++) begin
				tbl_num[s][v] = tbl_num[last][v];
				tbl_off[s][v] = tbl_off[last][v];
				tbl_len[s][v] = tbl_len[last][v];
			end
		end
		keys_held = last;
	endfunction

	// Apply one request to the shadow table and return the response it must give
	function automatic rsp_t apply_request(req_t r);
		rsp_t o;
		int s, n, v, lim;
		logic [30:0] num;
		o = '0;
		o.status = ST_MISS;
		s = find_key(r.key);
		n = (s >= 0) ? tbl_cnt[s] : 0;
		case (r.mode)
			MODE_ADD: begin
				if (s >= 0) begin
					if (n >= VERS) begin
						o.status = ST_FULL;
						o.versions_held = 4'(n);
						return o;
					end
					num = (n > 0) ? tbl_num[s][0] : '0;
					num = (num == VER_MAX) ? VER_MAX : num + 1;
					for (int i = n; i > 0; i--) begin
						tbl_num[s][i] = tbl_num[s][i-1];
						tbl_off[s][i] = tbl_off[s][i-1];
						tbl_len[s][i] = tbl_len[s][i-1];
					end
					n++;
				end else begin
					lim = (cap_limit < SLOTS) ? cap_limit : SLOTS;
					if (keys_held >= lim) begin
						o.status = ST_FULL;
						return o;
					end
					s = keys_held;
					tbl_key[s] = r.key;
					keys_held++;
					num = 1;
					n = 1;
				end
				tbl_num[s][0] = num;
				tbl_off[s][0] = data_end;
				tbl_len[s][0] = r.text_len;
				tbl_cnt[s] = n;
				o = '{ST_OK, num, data_end, r.text_len, 4'(n)};
				data_end = data_end + r.text_len;
			end
			MODE_DEL_KEY: begin
				if (s >= 0) begin
					drop_key(s);
					o.status = ST_OK;
				end
			end
			MODE_DEL_VER, MODE_FIND_VER: begin
				if (s < 0) return o;
				for (v = 0; v < n; v++)
					if (tbl_num[s][v] == r.version) break;
				o.versions_held = 4'(n);
				if (v >= n) return o;
				o.status = ST_OK;
				o.found_version = tbl_num[s][v];
				o.data_offset = tbl_off[s][v];
				o.data_len = tbl_len[s][v];
				if (r.mode == MODE_DEL_VER) begin
					if (n <= 1) begin
						drop_key(s);
						o.versions_held = 0;
					end else begin
						for (int i = v; i + 1 < n; i++) begin
							tbl_num[s][i] = tbl_num[s][i+1];
							tbl_off[s][i] = tbl_off[s][i+1];
							tbl_len[s][i] = tbl_len[s][i+1];
						end
						tbl_cnt[s] = n - 1;
						o.versions_held = 4'(n - 1);
					end
				end
			end
			MODE_FIND_KEY: begin
				if (s >= 0 && n > 0)
					o = '{ST_OK, tbl_num[s][0], tbl_off[s][0], tbl_len[s][0], 4'(n)};
			end
			default: ;
		endcase
		return o;
	endfunction

	// Driver: bursts of items with random gaps, held while stalled
	int burst_left = 0, gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_item <= '0;
		end else if (!(req_valid && req_stall)) begin
			if (req_valid)
				expected_rsps.push_back(apply_request(req_item));
			if (gap_left > 0 || cfg_busy || pending_reqs.size() == 0) begin
				if (gap_left > 0) gap_left--;
				req_valid <= 1'b0;
			end else begin
				req_item <= pending_reqs.pop_front();
				req_valid <= 1'b1;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
				end else
					burst_left--;
			end
		end
	end

	// Receiver stall pattern and response checker
	int stall_phase = 0;
	int idle_cycles = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (rsp_valid && !rsp_stall) begin
				rsp_t exp_rsp;
				if (expected_rsps.size() == 0) begin
					$error("response with none expected: %p", rsp_item);
					fail_count++;
				end else begin
					exp_rsp = expected_rsps.pop_front();
					if (rsp_item.status !== exp_rsp.status) begin
						$error("status exp %0d got %0d", exp_rsp.status, rsp_item.status);
						fail_count++;
					end
					if (rsp_item.found_version !== exp_rsp.found_version) begin
						$error("found_version exp %0d got %0d", exp_rsp.found_version,
							rsp_item.found_version);
						fail_count++;
					end
					if (rsp_item.data_offset !== exp_rsp.data_offset) begin
						$error("data_offset exp %0d got %0d", exp_rsp.data_offset,
							rsp_item.data_offset);
						fail_count++;
					end
					if (rsp_item.data_len !== exp_rsp.data_len) begin
						$error("data_len exp %0d got %0d", exp_rsp.data_len, rsp_item.data_len);
						fail_count++;
					end
					if (rsp_item.versions_held !== exp_rsp.versions_held) begin
						$error("versions_held exp %0d got %0d", exp_rsp.versions_held,
							rsp_item.versions_held);
						fail_count++;
					end
				end
			end
			// Cycle through quiet, light and heavy stall stretches
			stall_phase = (stall_phase + 1) % 600;
			if (stall_phase < 200) rsp_stall <= 1'b0;
			else if (stall_phase < 400) rsp_stall <= ($urandom_range(0, 3) == 0);
			else rsp_stall <= ($urandom_range(0, 3) != 0);
			if (idle_cycles > WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Keys from a small pool so that hits are common
	logic [31:0] key_pool [8];

	function automatic req_t make_req(logic [2:0] m, logic [31:0] k, logic [30:0] v,
			logic [15:0] l);
		req_t r;
		r.mode = m;
		r.key = k;
		r.version = v;
		r.text_len = l;
		return r;
	endfunction

	function automatic logic [15:0] rand_len();
		case ($urandom_range(0, 4))
			0: return 16'hFFFF;
			1: return 16'(0);
			default: return 16'($urandom_range(1, 64));
		endcase
	endfunction

	function automatic req_t rand_req();
		logic [31:0] k;
		logic [2:0] m;
		logic [30:0] v;
		k = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, 7)];
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5, 6, 7: m = MODE_ADD;
			8: m = MODE_DEL_KEY;
			9, 10, 11: m = MODE_DEL_VER;
			12, 13, 14: m = MODE_FIND_KEY;
			15, 16, 17, 18: m = MODE_FIND_VER;
			default: m = 3'($urandom_range(5, 7));
		endcase
		v = ($urandom_range(0, 7) == 0) ? 31'($urandom) : 31'($urandom_range(0, 12));
		return make_req(m, k, v, rand_len());
	endfunction

	// Wait until the block has returned everything, then let it settle
	task automatic drain_block();
		while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_capacity(logic [4:0] c);
		drain_block();
		cfg_busy = 1;
		cfg_we <= 1'b1;
		cfg_data <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		cap_limit = c;
		cfg_busy = 0;
	endtask

	initial begin
		logic [4:0] caps [5];
		arst_n = 0;
		cfg_we = 0;
		cfg_data = '0;
		keys_held = 0;
		data_end = '0;
		cap_limit = CAP_RESET;
		caps = '{5'd0, 5'd31, 5'd3, 5'd16, 5'd1};
		for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7FFF_FFFF;
		key_pool[2] = 32'hFFFF_FFFF;
		key_pool[3] = 32'h0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes, every mode, version list full, misses, unknown modes
		pending_reqs.push_back(make_req(MODE_FIND_KEY, key_pool[0], 0, 1));
		pending_reqs.push_back(make_req(MODE_ADD, key_pool[0], 31'h7FFF_FFFF, 16'hFFFF));
		for (int i = 0; i < 8; i++)
			pending_reqs.push_back(make_req(MODE_ADD, key_pool[1], 0, 16'(i)));
		pending_reqs.push_back(make_req(MODE_FIND_VER, key_pool[1], 31'd5, 1));
		pending_reqs.push_back(make_req(MODE_FIND_VER, key_pool[1], 31'h7FFF_FFFF, 1));
		pending_reqs.push_back(make_req(MODE_DEL_VER, key_pool[1], 31'd3, 1));
		pending_reqs.push_back(make_req(MODE_DEL_VER, key_pool[1], 31'd3, 1));
		pending_reqs.push_back(make_req(MODE_FIND_KEY, key_pool[1], 0, 1));
		pending_reqs.push_back(make_req(MODE_ADD, key_pool[2], 0, 16'd1));
		pending_reqs.push_back(make_req(MODE_DEL_VER, key_pool[2], 31'd1, 1));
		pending_reqs.push_back(make_req(MODE_DEL_KEY, key_pool[0], 0, 1));
		pending_reqs.push_back(make_req(MODE_DEL_KEY, key_pool[0], 0, 1));
		pending_reqs.push_back(make_req(3'd5, key_pool[1], 31'h7FFF_FFFF, 16'hFFFF));
		pending_reqs.push_back(make_req(3'd7, key_pool[3], 0, 0));
		pending_reqs.push_back(make_req(MODE_FIND_VER, 32'h1234_5678, 31'd1, 1));
		pending_reqs.push_back(make_req(MODE_DEL_VER, 32'h1234_5678, 31'd1, 1));

		// Random phases over several capacity settings, the extremes among them
		for (int p = 0; p < 5; p++) begin
			write_capacity(caps[p]);
			for (int i = 0; i < 190; i++) pending_reqs.push_back(rand_req());
		end
		// Fill the table with fresh keys to reach table full
		for (int i = 0; i < 20; i++)
			pending_reqs.push_back(make_req(MODE_ADD, $urandom, 31'($urandom), rand_len()));

		drain_block();
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

### sim.f
design/vkt_pkg.sv
design/vkt_ram.sv
design/vkt_ctrl.sv
design/vkt_dp.sv
design/versioned_key_table_top.sv
design/vkt_checker.sv
verif/versioned_key_table_top_test.sv
